/* hw/rtl/cl30gp_pkg.sv */
// Shared constants, blade sign and slot helpers, and operation codes for the Cl(3,0) product unit.
package cl30gp_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int FRACTION_BITS_DEF  = 12;
    localparam int BLADES             = 8;
    localparam int FIELD_BITS         = 64;

    typedef logic [2:0] t_slot;

    // slot to blade bit mask (self-inverse permutation)
    function automatic logic [2:0] blade_bits(input logic [2:0] s);
        logic [2:0] r;
        begin
            unique case (s)
                3'd3:    r = 3'd4;
                3'd4:    r = 3'd3;
                default: r = s;
            endcase
            return r;
        end
    endfunction

    // true where the product of blade masks a and b carries a minus sign
    function automatic logic blade_negative(input logic [2:0] ma, input logic [2:0] mb);
        logic p;
        begin
            p = (ma[1] & mb[0]) ^ (ma[2] & mb[0]) ^ (ma[2] & mb[1]);
            return p;
        end
    endfunction

    // product slot for slots i and j
    function automatic t_slot prod_slot(input logic [2:0] i, input logic [2:0] j);
        t_slot s;
        begin
            s = blade_bits(blade_bits(i) ^ blade_bits(j));
            return s;
        end
    endfunction

    typedef enum logic {
        OP_PRODUCT  = 1'b0,
        OP_SANDWICH = 1'b1
    } t_op;

endpackage

/* hw/rtl/cl30gp_product.sv */
// Pipelined geometric product of two multivectors: multiply, sum, round and saturate.
module cl30gp_product
    import cl30gp_pkg::*;
#(
    parameter int IN_BITS   = COMPONENT_BITS_DEF + 1,
    parameter int OUT_BITS  = COMPONENT_BITS_DEF,
    parameter int FRAC_BITS = FRACTION_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [BLADES-1:0][IN_BITS-1:0] i_x,
    input  logic signed [BLADES-1:0][IN_BITS-1:0] i_y,
    output logic signed [BLADES-1:0][OUT_BITS-1:0] o_z,
    output logic                                  o_clip
);
    localparam int PROD_BITS = 2 * IN_BITS + 1;
    localparam int SUM_BITS  = PROD_BITS + 3;

    logic signed [BLADES-1:0][BLADES-1:0][PROD_BITS-1:0] r_prod;
    logic signed [BLADES-1:0][SUM_BITS-1:0]              r_sum;
    logic signed [BLADES-1:0][SUM_BITS-1:0]              n_sum;
    logic signed [BLADES-1:0][OUT_BITS-1:0]              n_z;
    logic                                                n_clip;

    // stage 1: products placed by destination slot with their signs applied
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < BLADES; i++) begin
                for (int j = 0; j < BLADES; j++) begin
                    if (blade_negative(blade_bits(3'(i)), blade_bits(3'(j))))
                        r_prod[prod_slot(3'(i), 3'(j))][i] <=
                            -(PROD_BITS'($signed(i_x[i])) * PROD_BITS'($signed(i_y[j])));
                    else
                        r_prod[prod_slot(3'(i), 3'(j))][i] <=
                            PROD_BITS'($signed(i_x[i])) * PROD_BITS'($signed(i_y[j]));
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < BLADES; k++) begin
            n_sum[k] = SUM_BITS'(signed'(1)) <<< (FRAC_BITS - 1);
            for (int i = 0; i < BLADES; i++)
                n_sum[k] = n_sum[k] + SUM_BITS'($signed(r_prod[k][i]));
        end
    end

    // stage 2: sums with rounding bias
    always_ff @(posedge i_clk) begin
        if (i_en) r_sum <= n_sum;
    end

    always_comb begin
        logic signed [SUM_BITS-1:0] q;
        logic signed [SUM_BITS-1:0] lim_hi;
        logic signed [SUM_BITS-1:0] lim_lo;
        lim_hi = SUM_BITS'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
        lim_lo = -lim_hi - SUM_BITS'(signed'(1));
        n_clip = 1'b0;
        for (int k = 0; k < BLADES; k++) begin
            q = $signed(r_sum[k]) >>> FRAC_BITS;
            if (q > lim_hi) begin
                n_z[k] = lim_hi[OUT_BITS-1:0];
                n_clip = 1'b1;
            end else if (q < lim_lo) begin
                n_z[k] = lim_lo[OUT_BITS-1:0];
                n_clip = 1'b1;
            end else begin
                n_z[k] = q[OUT_BITS-1:0];
            end
        end
    end

    // stage 3: saturated result
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_z    <= n_z;
            o_clip <= n_clip;
        end
    end
endmodule

/* hw/rtl/cl30_geometric_product_unit_core.sv */
// Top level of the Cl(3,0) geometric product and rotor sandwich unit.
// Takes one request per clock while the output is not stalled and returns one result per
// request, in order. The first product pipeline (multiply, sum, round and saturate) feeds
// a second product pipeline of the same stages for a rotor sandwich, and a plain product
// is delayed alongside it, so both operations reach the output register equally late and
// order is kept. A stall of the output freezes the whole pipeline; the input is stalled
// only while the output is stalled and the output register is full.
module cl30_geometric_product_unit_core
    import cl30gp_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_operation,
    input  logic [FIELD_BITS-1:0]            i_first_low,
    input  logic [FIELD_BITS-1:0]            i_first_high,
    input  logic [FIELD_BITS-1:0]            i_second_low,
    input  logic [FIELD_BITS-1:0]            i_second_high,
    input  logic                             i_last_pair,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [COMPONENT_BITS-1:0] o_res_scalar,
    output logic signed [COMPONENT_BITS-1:0] o_res_e1,
    output logic signed [COMPONENT_BITS-1:0] o_res_e2,
    output logic signed [COMPONENT_BITS-1:0] o_res_e3,
    output logic signed [COMPONENT_BITS-1:0] o_res_e12,
    output logic signed [COMPONENT_BITS-1:0] o_res_e13,
    output logic signed [COMPONENT_BITS-1:0] o_res_e23,
    output logic signed [COMPONENT_BITS-1:0] o_res_e123,
    output logic                             o_clamped,
    output logic                             o_last_result
);
    localparam int CB    = COMPONENT_BITS;
    localparam int XB    = CB + 1;
    localparam int DEPTH = 7;
    localparam int PB_LAT = 3;

    typedef struct packed {
        logic op;
        logic last;
    } t_tag;

    logic                          en;
    logic [DEPTH-1:0]              r_vld;
    t_tag [DEPTH-2:0]              r_tag;
    logic signed [BLADES-1:0][XB-1:0] a_in, b_in;
    logic signed [BLADES-1:0][CB-1:0] mid_z, fin_z;
    logic                          mid_clip, fin_clip;
    logic signed [BLADES-1:0][XB-1:0] r_rev [PB_LAT];
    logic signed [BLADES-1:0][XB-1:0] r_x2 [PB_LAT];
    logic signed [BLADES-1:0][XB-1:0] mid_ext;

    // the whole pipeline advances unless a full output is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    function automatic logic signed [XB-1:0] field(input logic [FIELD_BITS-1:0] w,
                                                   input int idx);
        logic [CB-1:0] raw;
        begin
            raw = '0;
            for (int b = 0; b < CB; b++)
                if (idx * CB + b < FIELD_BITS) raw[b] = w[idx*CB+b];
            if (idx * CB >= FIELD_BITS) raw = '0;
            return XB'(signed'(raw));
        end
    endfunction

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            a_in[k]   = field(i_first_low, k);
            a_in[k+4] = field(i_first_high, k);
            b_in[k]   = field(i_second_low, k);
            b_in[k+4] = field(i_second_high, k);
        end
    end

    cl30gp_product #(.IN_BITS(XB), .OUT_BITS(CB), .FRAC_BITS(FRACTION_BITS)) u_first (
        .i_clk (i_clk), .i_en(en), .i_x(a_in), .i_y(b_in), .o_z(mid_z), .o_clip(mid_clip)
    );

    // carry reverse(r) alongside the first product
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < BLADES; k++)
                r_rev[0][k] <= (k < 4) ? a_in[k] : -a_in[k];
            for (int s = 1; s < PB_LAT; s++) r_rev[s] <= r_rev[s-1];
        end
    end

    always_comb begin
        for (int k = 0; k < BLADES; k++) mid_ext[k] = XB'($signed(mid_z[k]));
    end

    cl30gp_product #(.IN_BITS(XB), .OUT_BITS(CB), .FRAC_BITS(FRACTION_BITS)) u_second (
        .i_clk (i_clk), .i_en(en), .i_x(mid_ext), .i_y(r_rev[PB_LAT-1]), .o_z(fin_z),
        .o_clip(fin_clip)
    );

    // hold the first product for the plain operation
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x2[0] <= mid_ext;
            for (int s = 1; s < PB_LAT; s++) r_x2[s] <= r_x2[s-1];
        end
    end

    logic [PB_LAT-1:0] r_cl;
    always_ff @(posedge i_clk) begin
        if (en) r_cl <= {r_cl[PB_LAT-2:0], mid_clip};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[0] <= '{op: i_operation, last: i_last_pair};
            for (int s = 1; s < DEPTH - 1; s++) r_tag[s] <= r_tag[s-1];
        end
    end

    // output register, stage 7
    t_tag out_tag;
    logic signed [BLADES-1:0][CB-1:0] res;
    logic res_clip;
    assign out_tag = r_tag[DEPTH-2];
    always_comb begin
        if (out_tag.op == OP_SANDWICH) begin
            res      = fin_z;
            res_clip = fin_clip || r_cl[PB_LAT-1];
        end else begin
            for (int k = 0; k < BLADES; k++) res[k] = r_x2[PB_LAT-1][k][CB-1:0];
            res_clip = r_cl[PB_LAT-1];
        end
    end

    logic signed [BLADES-1:0][CB-1:0] r_res;
    logic r_res_clip, r_res_last;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res      <= res;
            r_res_clip <= res_clip;
            r_res_last <= out_tag.last;
        end
    end

    assign o_valid       = r_vld[DEPTH-1];
    assign o_res_scalar  = r_res[0];
    assign o_res_e1      = r_res[1];
    assign o_res_e2      = r_res[2];
    assign o_res_e3      = r_res[3];
    assign o_res_e12     = r_res[4];
    assign o_res_e13     = r_res[5];
    assign o_res_e23     = r_res[6];
    assign o_res_e123    = r_res[7];
    assign o_clamped     = r_res_clip;
    assign o_last_result = r_res_last;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res_scalar) && $stable(o_clamped))
        else $error("result changed under stall");
    a_no_input_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");
    a_valid_travels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[DEPTH-2] |=> o_valid)
        else $error("valid lost in pipeline");
endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the Cl(3,0) geometric product and rotor sandwich unit.
`timescale 1ns / 1ps

module testbench
    import cl30gp_pkg::*;
();

    localparam int CB = 16;
    localparam int FB = 12;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        t_op         op;
        logic [63:0] first_low;
        logic [63:0] first_high;
        logic [63:0] second_low;
        logic [63:0] second_high;
        logic        last_pair;
    } t_request;

    typedef struct packed {
        logic signed [7:0][CB-1:0] blade;
        logic                      clamped;
        logic                      last_result;
    } t_multivector_result;

    typedef logic signed [CB:0] t_comp_arr [8];

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_operation = 1'b0;
    logic [63:0] i_first_low = '0, i_first_high = '0, i_second_low = '0, i_second_high = '0;
    logic i_last_pair = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [CB-1:0] o_res_scalar, o_res_e1, o_res_e2, o_res_e3;
    logic signed [CB-1:0] o_res_e12, o_res_e13, o_res_e23, o_res_e123;
    logic o_clamped, o_last_result;

    cl30_geometric_product_unit_core uut (.*);

    always #6 i_clk = ~i_clk;

    t_request            pending_requests[$];
    t_multivector_result expected_products[$];
    int  errors = 0;
    int  accepted = 0;
    int  results_seen = 0;
    int  clamp_seen = 0;
    int  watchdog = 0;
    int  send_idle_pct = 15;
    int  recv_idle_pct = 88;
    bit  hold_send = 1'b0;
    bit  stimulus_done = 1'b0;
    bit  took = 1'b0;

    // one exact sum per blade, rounded and saturated
    function automatic logic signed [CB-1:0] round_clip(input logic signed [63:0] acc,
                                                        inout bit clip);
        logic signed [63:0] q;
        q = (acc + (64'sd1 <<< (FB - 1))) >>> FB;
        if (q > 64'sd32767) begin
            clip = 1'b1;
            return 16'sh7fff;
        end
        if (q < -64'sd32768) begin
            clip = 1'b1;
            return 16'sh8000;
        end
        return q[CB-1:0];
    endfunction

    function automatic void blade_product(input t_comp_arr x, input t_comp_arr y,
                                          output t_comp_arr z, inout bit clip);
        logic signed [63:0] acc[8];
        logic signed [63:0] p;
        logic [2:0] ma, mb, k;
        int n;
        for (int i = 0; i < 8; i++) acc[i] = 0;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                ma = (i == 3) ? 3'd4 : (i == 4) ? 3'd3 : 3'(i);
                mb = (j == 3) ? 3'd4 : (j == 4) ? 3'd3 : 3'(j);
                k = ma ^ mb;
                k = (k == 3'd3) ? 3'd4 : (k == 3'd4) ? 3'd3 : k;
                n = (ma[1] & mb[0]) + (ma[2] & mb[0]) + (ma[2] & mb[1]);
                p = 64'(x[i]) * 64'(y[j]);
                acc[k] += n[0] ? -p : p;
            end
        end
        for (int i = 0; i < 8; i++) z[i] = round_clip(acc[i], clip);
    endfunction

    function automatic t_multivector_result predict_product(input t_request rq);
        t_comp_arr a, b, mid, rev, r;
        t_multivector_result res;
        bit clip;
        clip = 1'b0;
        for (int i = 0; i < 4; i++) begin
            a[i]   = $signed(rq.first_low[16*i +: 16]);
            a[i+4] = $signed(rq.first_high[16*i +: 16]);
            b[i]   = $signed(rq.second_low[16*i +: 16]);
            b[i+4] = $signed(rq.second_high[16*i +: 16]);
        end
        blade_product(a, b, mid, clip);
        if (rq.op == OP_SANDWICH) begin
            for (int i = 0; i < 8; i++) rev[i] = (i < 4) ? a[i] : -a[i];
            blade_product(mid, rev, r, clip);
        end else begin
            r = mid;
        end
        for (int i = 0; i < 8; i++) res.blade[i] = r[i][CB-1:0];
        res.clamped = clip;
        res.last_result = rq.last_pair;
        return res;
    endfunction

    function automatic logic [15:0] rand_comp(input int kind);
        case (kind)
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(0);
            3: return 16'($urandom_range(0, 8192) - 4096);
            4: return 16'($urandom_range(0, 2048) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_field(input int kind);
        logic [63:0] f;
        for (int i = 0; i < 4; i++) f[16*i +: 16] = rand_comp(kind < 0 ? $urandom_range(0, 5) : kind);
        return f;
    endfunction

    task automatic add_request(input t_op op, input logic [63:0] fl, input logic [63:0] fh,
                               input logic [63:0] sl, input logic [63:0] sh, input logic lp);
        t_request rq;
        rq = '{op, fl, fh, sl, sh, lp};
        pending_requests.push_back(rq);
    endtask

    // driver: hold a waiting request, else present the head request or idle; randomly stall the output
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (pending_requests.size() > 0 &&
                ((i_valid && !took) ||
                 (!hold_send && $urandom_range(0, 99) >= send_idle_pct))) begin
                i_valid       <= 1'b1;
                i_operation   <= pending_requests[0].op;
                i_first_low   <= pending_requests[0].first_low;
                i_first_high  <= pending_requests[0].first_high;
                i_second_low  <= pending_requests[0].second_low;
                i_second_high <= pending_requests[0].second_high;
                i_last_pair   <= pending_requests[0].last_pair;
            end else begin
                i_valid <= 1'b0;
            end
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // monitor: take accepted requests, check results and keep the watchdog
    always @(posedge i_clk) begin
        t_multivector_result got, want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_products.push_back(predict_product(pending_requests.pop_front()));
                accepted++;
                took = 1'b1;
            end else begin
                took = 1'b0;
            end
            if (o_valid && !i_stall) begin
                got = '{'{o_res_e123, o_res_e23, o_res_e13, o_res_e12,
                          o_res_e3, o_res_e2, o_res_e1, o_res_scalar},
                        o_clamped, o_last_result};
                results_seen++;
                if (o_clamped) clamp_seen++;
                if (expected_products.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = expected_products.pop_front();
                    for (int i = 0; i < 8; i++)
                        if (got.blade[i] !== want.blade[i]) begin
                            $display("%0t: blade %0d expected %0d actual %0d", $time, i,
                                     want.blade[i], got.blade[i]);
                            errors++;
                        end
                    if (got.clamped !== want.clamped) begin
                        $display("%0t: clamped expected %b actual %b", $time,
                                 want.clamped, got.clamped);
                        errors++;
                    end
                    if (got.last_result !== want.last_result) begin
                        $display("%0t: last expected %b actual %b", $time,
                                 want.last_result, got.last_result);
                        errors++;
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) watchdog = 0;
            else watchdog++;
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] one;
        one = 64'h0000_0000_0000_1000;
        // directed: extremes, identities, both operations, clamping
        add_request(OP_PRODUCT, one, '0, rand_field(-1), rand_field(-1), 1'b0);
        add_request(OP_PRODUCT, '0, '0, '0, '0, 1'b1);
        add_request(OP_PRODUCT, '1, '1, '1, '1, 1'b0);
        add_request(OP_PRODUCT, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, 1'b0);
        add_request(OP_PRODUCT, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 1'b1);
        add_request(OP_PRODUCT, {4{16'h8000}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h8000}}, 1'b0);
        add_request(OP_SANDWICH, one, '0, rand_field(4), rand_field(4), 1'b0);
        add_request(OP_SANDWICH, '0, 64'h8000_0000_0000_0000, rand_field(4), rand_field(4), 1'b0);
        add_request(OP_SANDWICH, 64'h8000, '0, rand_field(3), rand_field(3), 1'b0);
        add_request(OP_SANDWICH, 64'h0000_0000_0000_0b50, 64'h0000_0000_0000_0b50,
                    rand_field(3), rand_field(3), 1'b1);
        add_request(OP_SANDWICH, {4{16'h8000}}, {4{16'h8000}}, {4{16'h7fff}}, {4{16'h8000}}, 1'b0);
        add_request(OP_SANDWICH, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, 1'b1);
        for (int i = 0; i < 8; i++) begin
            add_request(t_op'(i[0]), 64'hffff << (16 * (i % 4)), 64'h0800 << (16 * (i % 4)),
                        rand_field(-1), rand_field(-1), i[1]);
        end
        for (int i = 0; i < 550; i++) begin
            int k;
            k = $urandom_range(0, 9);
            add_request(t_op'($urandom_range(0, 1)), rand_field(k < 6 ? 4 : -1),
                        rand_field(k < 6 ? 4 : -1), rand_field(k < 3 ? 3 : -1),
                        rand_field(k < 3 ? 3 : -1), 1'($urandom));
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (accepted >= 200);
        // pause the sender until the pipeline has drained
        @(negedge i_clk);
        hold_send = 1'b1;
        wait (expected_products.size() == 0);
        @(negedge i_clk);
        hold_send = 1'b0;
        send_idle_pct = 88;
        recv_idle_pct = 15;
        wait (accepted >= 400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait (pending_requests.size() == 0);
        wait (expected_products.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("Ran %0d requests, both operations, %0d results checked, %0d clamped.",
                 accepted, results_seen, clamp_seen);
        if (errors == 0 && expected_products.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/cl30gp_pkg.sv
hw/rtl/cl30gp_product.sv
hw/rtl/cl30_geometric_product_unit_core.sv
tb/sv/testbench.sv
